// ----- rtl/core/sbalu_pkg.sv -----
// ----------------------------------------------------------------------------
// sbalu_pkg
// Types, opcodes and constants shared by the 16-bit CPU execute unit.
// ----------------------------------------------------------------------------
package sbalu_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned DIV_STEPS   = 32;

    // Basic two-operand opcodes
    localparam logic [4:0] OP_SET = 5'h01;
    localparam logic [4:0] OP_ADD = 5'h02;
    localparam logic [4:0] OP_SUB = 5'h03;
    localparam logic [4:0] OP_MUL = 5'h04;
    localparam logic [4:0] OP_MLI = 5'h05;
    localparam logic [4:0] OP_DIV = 5'h06;
    localparam logic [4:0] OP_DVI = 5'h07;
    localparam logic [4:0] OP_MOD = 5'h08;
    localparam logic [4:0] OP_MDI = 5'h09;
    localparam logic [4:0] OP_AND = 5'h0a;
    localparam logic [4:0] OP_BOR = 5'h0b;
    localparam logic [4:0] OP_XOR = 5'h0c;
    localparam logic [4:0] OP_SHR = 5'h0d;
    localparam logic [4:0] OP_ASR = 5'h0e;
    localparam logic [4:0] OP_SHL = 5'h0f;
    localparam logic [4:0] OP_IFB = 5'h10;
    localparam logic [4:0] OP_IFC = 5'h11;
    localparam logic [4:0] OP_IFE = 5'h12;
    localparam logic [4:0] OP_IFN = 5'h13;
    localparam logic [4:0] OP_IFG = 5'h14;
    localparam logic [4:0] OP_IFA = 5'h15;
    localparam logic [4:0] OP_IFL = 5'h16;
    localparam logic [4:0] OP_IFU = 5'h17;
    localparam logic [4:0] OP_ADX = 5'h1a;
    localparam logic [4:0] OP_SBX = 5'h1b;
    localparam logic [4:0] OP_STI = 5'h1e;
    localparam logic [4:0] OP_STD = 5'h1f;

    // Index step codes
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_INC  = 2'd1;
    localparam logic [1:0] STEP_DEC  = 2'd2;

    // Job class seen by the back end
    typedef enum logic [2:0] {
        K_SIMPLE,
        K_DIV,
        K_MOD,
        K_DVI,
        K_MDI
    } t_kind;

    typedef struct packed {
        logic [4:0]  op_code;
        logic [15:0] a_value;
        logic [15:0] b_value;
        logic [15:0] ex_in;
    } t_in;

    typedef struct packed {
        logic [15:0] result_word;
        logic        write_result;
        logic [15:0] ex_out;
        logic        write_ex;
        logic        skip_next;
        logic [1:0]  index_step;
        logic        illegal_op;
    } t_out;

    typedef struct packed {
        t_kind       kind;
        t_out        simple;
        logic        div_zero;
        logic        neg_q;
        logic        neg_r;
        logic [15:0] mag_a;
        logic [15:0] mag_b;
    } t_job;

endpackage

// ----- rtl/core/sbalu_front.sv -----
// ----------------------------------------------------------------------------
// sbalu_front
// Decode an instruction and finish every operation except division and modulo.
// ----------------------------------------------------------------------------
module sbalu_front (
    input  sbalu_pkg::t_in  i_in,
    output sbalu_pkg::t_job o_job
);

    logic [15:0]        a, b, ex;
    logic [31:0]        w_prod;
    logic [16:0]        w_add;
    logic [17:0]        w_adx;
    logic signed [17:0] w_sbx;
    logic [31:0]        w_shr;
    logic signed [31:0] w_asr_r;
    logic signed [31:0] w_asr_e;
    logic [31:0]        w_shl;
    logic               w_small;

    assign a  = i_in.a_value;
    assign b  = i_in.b_value;
    assign ex = i_in.ex_in;

    // Shared datapath pieces
    assign w_prod  = 32'(a) * 32'(b);
    assign w_add   = {1'b0, a} + {1'b0, b};
    assign w_adx   = {2'b0, b} + {2'b0, a} + {2'b0, ex};
    assign w_sbx   = $signed({2'b0, b}) - $signed({2'b0, a}) + $signed({2'b0, ex});
    assign w_shr   = {b, 16'h0} >> a[4:0];
    assign w_asr_r = $signed({{16{b[15]}}, b}) >>> a[4:0];
    assign w_asr_e = $signed({b, 16'h0}) >>> a[4:0];
    assign w_shl   = {16'h0, b} << a[4:0];
    assign w_small = (a[15:5] == 11'h0);

    // Classify and select
    always_comb begin
        o_job          = '0;
        o_job.kind     = sbalu_pkg::K_SIMPLE;
        o_job.div_zero = (a == 16'h0);
        o_job.neg_q    = a[15] ^ b[15];
        o_job.neg_r    = b[15];
        o_job.mag_a    = a;
        o_job.mag_b    = b;
        case (i_in.op_code)
            sbalu_pkg::OP_SET: begin
                o_job.simple.result_word  = a;
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_ADD: begin
                o_job.simple.result_word  = w_add[15:0];
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                o_job.simple.ex_out       = {15'h0, w_add[16]};
            end
            sbalu_pkg::OP_SUB: begin
                o_job.simple.result_word  = b - a;
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                o_job.simple.ex_out       = (b < a) ? 16'hffff : 16'h0;
            end
            sbalu_pkg::OP_MUL: begin
                o_job.simple.result_word  = w_prod[15:0];
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                o_job.simple.ex_out       = w_prod[31:16];
            end
            sbalu_pkg::OP_MLI: begin
                // low half of a signed product equals the unsigned one
                o_job.simple.result_word  = w_prod[15:0];
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_DIV: begin
                o_job.kind                = sbalu_pkg::K_DIV;
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
            end
            sbalu_pkg::OP_MOD: begin
                o_job.kind                = sbalu_pkg::K_MOD;
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_DVI: begin
                o_job.kind                = sbalu_pkg::K_DVI;
                o_job.simple.write_result = 1'b1;
                o_job.mag_a               = a[15] ? (16'h0 - a) : a;
                o_job.mag_b               = b[15] ? (16'h0 - b) : b;
            end
            sbalu_pkg::OP_MDI: begin
                o_job.kind                = sbalu_pkg::K_MDI;
                o_job.simple.write_result = 1'b1;
                o_job.mag_a               = a[15] ? (16'h0 - a) : a;
                o_job.mag_b               = b[15] ? (16'h0 - b) : b;
            end
            sbalu_pkg::OP_AND: begin
                o_job.simple.result_word  = a & b;
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_BOR: begin
                o_job.simple.result_word  = a | b;
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_XOR: begin
                o_job.simple.result_word  = a ^ b;
                o_job.simple.write_result = 1'b1;
            end
            sbalu_pkg::OP_SHR: begin
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                if (w_small) begin
                    o_job.simple.result_word = w_shr[31:16];
                    o_job.simple.ex_out      = w_shr[15:0];
                end
            end
            sbalu_pkg::OP_ASR: begin
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                if (w_small) begin
                    o_job.simple.result_word = w_asr_r[15:0];
                    o_job.simple.ex_out      = w_asr_e[15:0];
                end
            end
            sbalu_pkg::OP_SHL: begin
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                if (w_small) begin
                    o_job.simple.result_word = w_shl[15:0];
                    o_job.simple.ex_out      = w_shl[31:16];
                end
            end
            sbalu_pkg::OP_IFB: o_job.simple.skip_next = ((b & a) == 16'h0);
            sbalu_pkg::OP_IFC: o_job.simple.skip_next = ((b & a) != 16'h0);
            sbalu_pkg::OP_IFE: o_job.simple.skip_next = (b != a);
            sbalu_pkg::OP_IFN: o_job.simple.skip_next = (b == a);
            sbalu_pkg::OP_IFG: o_job.simple.skip_next = !(b > a);
            sbalu_pkg::OP_IFA: o_job.simple.skip_next = !($signed(b) > $signed(a));
            sbalu_pkg::OP_IFL: o_job.simple.skip_next = !(b < a);
            sbalu_pkg::OP_IFU: o_job.simple.skip_next = !($signed(b) < $signed(a));
            sbalu_pkg::OP_ADX: begin
                o_job.simple.result_word  = w_adx[15:0];
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                o_job.simple.ex_out       = (w_adx[17:16] != 2'b0) ? 16'h1 : 16'h0;
            end
            sbalu_pkg::OP_SBX: begin
                o_job.simple.result_word  = w_sbx[15:0];
                o_job.simple.write_result = 1'b1;
                o_job.simple.write_ex     = 1'b1;
                o_job.simple.ex_out       = w_sbx[17] ? 16'hffff :
                                            (w_sbx[16] ? 16'h1 : 16'h0);
            end
            sbalu_pkg::OP_STI: begin
                o_job.simple.result_word  = a;
                o_job.simple.write_result = 1'b1;
                o_job.simple.index_step   = sbalu_pkg::STEP_INC;
            end
            sbalu_pkg::OP_STD: begin
                o_job.simple.result_word  = a;
                o_job.simple.write_result = 1'b1;
                o_job.simple.index_step   = sbalu_pkg::STEP_DEC;
            end
            default: begin
                o_job.simple.illegal_op = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/core/sbalu_queue.sv -----
// ----------------------------------------------------------------------------
// sbalu_queue
// Short job queue between the decode front and the divide back end.
// ----------------------------------------------------------------------------
module sbalu_queue #(
    parameter int unsigned DEPTH = sbalu_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbalu_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sbalu_pkg::t_job o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sbalu_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/sbalu_back.sv -----
// ----------------------------------------------------------------------------
// sbalu_back
// Pipelined restoring divider, one quotient bit per stage, and result stage.
// ----------------------------------------------------------------------------
module sbalu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  sbalu_pkg::t_job  i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sbalu_pkg::t_out  o_out
);

    localparam int unsigned NS = sbalu_pkg::DIV_STEPS;

    typedef struct packed {
        sbalu_pkg::t_job job;
        logic [15:0]     rem;
        logic [15:0]     rem16;
        logic [31:0]     qd;
    } t_stg;

    t_stg            r_stg [NS+1];
    t_stg            n_stg [NS+1];
    logic [NS:0]     r_vld;
    logic            w_adv;
    t_stg            w_last;
    sbalu_pkg::t_out n_out;
    sbalu_pkg::t_out r_out;
    logic            r_ov;

    // Freeze the whole pipe while the result waits
    assign w_adv = !(r_ov && i_out_stall);
    assign o_pop = w_adv && i_job_valid;

    // One compare-subtract step per stage
    always_comb begin
        n_stg[0].job   = i_job;
        n_stg[0].rem   = 16'h0;
        n_stg[0].rem16 = 16'h0;
        n_stg[0].qd    = {i_job.mag_b, 16'h0};
        for (int k = 1; k <= NS; k++) begin
            logic [16:0] t;
            t              = {r_stg[k-1].rem, r_stg[k-1].qd[31]};
            n_stg[k].job   = r_stg[k-1].job;
            n_stg[k].rem16 = r_stg[k-1].rem16;
            if (t >= {1'b0, r_stg[k-1].job.mag_a}) begin
                t           = t - {1'b0, r_stg[k-1].job.mag_a};
                n_stg[k].qd = {r_stg[k-1].qd[30:0], 1'b1};
            end else begin
                n_stg[k].qd = {r_stg[k-1].qd[30:0], 1'b0};
            end
            n_stg[k].rem = t[15:0];
            if (k == 16) begin
                n_stg[k].rem16 = t[15:0];
            end
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k <= NS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-1:0], i_job_valid};
        end
    end

    // Pick the final fields
    assign w_last = r_stg[NS];
    always_comb begin
        n_out = w_last.job.simple;
        case (w_last.job.kind)
            sbalu_pkg::K_DIV: begin
                n_out.result_word = w_last.job.div_zero ? 16'h0 : w_last.qd[31:16];
                n_out.ex_out      = w_last.job.div_zero ? 16'h0 : w_last.qd[15:0];
            end
            sbalu_pkg::K_MOD: begin
                n_out.result_word = w_last.job.div_zero ? 16'h0 : w_last.rem16;
            end
            sbalu_pkg::K_DVI: begin
                n_out.result_word = w_last.job.div_zero ? 16'h0 :
                                    (w_last.job.neg_q ? 16'h0 - w_last.qd[31:16]
                                                      : w_last.qd[31:16]);
            end
            sbalu_pkg::K_MDI: begin
                n_out.result_word = w_last.job.div_zero ? 16'h0 :
                                    (w_last.job.neg_r ? 16'h0 - w_last.rem16
                                                      : w_last.rem16);
            end
            default: begin
                n_out = w_last.job.simple;
            end
        endcase
    end

    // Hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_vld[NS];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

// ----- rtl/core/sixteen_bit_cpu_alu_execute.sv -----
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_alu_execute
// Execute unit for two-operand instructions of a 16-bit CPU.
// ----------------------------------------------------------------------------
// Takes one instruction per cycle and returns one result per cycle in order
// while neither i_out_stall nor o_in_stall holds the flow. Every instruction
// takes the same path from input transfer to output valid: the decode queue,
// the divider pipeline (a load stage and 32 one-bit restoring steps), which
// every instruction travels so that results stay in order, and the output
// register. While a result waits on o_out the whole back end holds; the
// queue of QUEUE_DEPTH entries then fills and raises o_in_stall.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_alu_execute #(
    parameter int unsigned QUEUE_DEPTH = sbalu_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sbalu_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sbalu_pkg::t_out o_out
);

    sbalu_pkg::t_job w_dec_job;
    sbalu_pkg::t_job w_q_job;
    logic            w_q_full, w_q_valid, w_pop;

    // Decode and non-divide results
    sbalu_front u_front (
        .i_in  (i_in),
        .o_job (w_dec_job)
    );

    // Decouple front from back
    sbalu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (w_dec_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_job)
    );

    assign o_in_stall = w_q_full;

    // Divide pipeline and output register
    sbalu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
